@@ rtl/bsp_pkg.sv @@
// Shared constants and basis weight table for the cubic B-spline segment evaluator.
package bsp_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int SAMPLES_PER_SEGMENT = 4;
  localparam int NUM_SAMPLES = SAMPLES_PER_SEGMENT + 1;
  localparam int SAMPLE_BITS = $clog2(NUM_SAMPLES);
  localparam int NUM_CTRL = 4;
  localparam int WEIGHT_BITS = 9;
  localparam int WEIGHT_SHIFT = 7;
  localparam int QUEUE_DEPTH = 2;

  function automatic logic [WEIGHT_BITS-1:0] bsp_weight(
    input logic [SAMPLE_BITS-1:0] k,
    input logic [1:0] j
  );
    logic [4*WEIGHT_BITS-1:0] row;
    case (k)
      3'd0:    row = {9'd0,  9'd64,  9'd256, 9'd64};
      3'd1:    row = {9'd1,  9'd121, 9'd235, 9'd27};
      3'd2:    row = {9'd8,  9'd184, 9'd184, 9'd8};
      3'd3:    row = {9'd27, 9'd235, 9'd121, 9'd1};
      3'd4:    row = {9'd64, 9'd256, 9'd64,  9'd0};
      default: row = '0;
    endcase
    return row[j*WEIGHT_BITS +: WEIGHT_BITS];
  endfunction

endpackage

@@ rtl/bsp_front.sv @@
// Front end: control point window and segment issue into the queue.
module bsp_front import bsp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [COORD_BITS-1:0]          point_x,
  input  logic [COORD_BITS-1:0]          point_y,
  input  logic                           q_full,
  output logic                           full,
  output logic                           q_wr,
  output logic [2*NUM_CTRL*COORD_BITS-1:0] q_wdata
);

  logic [COORD_BITS-1:0] window_x [3];
  logic [COORD_BITS-1:0] window_y [3];
  logic [1:0]            points_held;
  logic                  accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept && (points_held == 2'd3);

  assign q_wdata = {point_y, window_y[2], window_y[1], window_y[0],
                    point_x, window_x[2], window_x[1], window_x[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      points_held <= '0;
      for (int i = 0; i < 3; i++) begin
        window_x[i] <= '0;
        window_y[i] <= '0;
      end
    end else if (accept) begin
      if (points_held == 2'd3) begin
        window_x[0] <= window_x[1];
        window_x[1] <= window_x[2];
        window_x[2] <= point_x;
        window_y[0] <= window_y[1];
        window_y[1] <= window_y[2];
        window_y[2] <= point_y;
      end else begin
        window_x[points_held] <= point_x;
        window_y[points_held] <= point_y;
        points_held <= points_held + 2'd1;
      end
    end
  end

endmodule

@@ rtl/bsp_seg_queue.sv @@
// Short segment queue between the front end and the evaluation pipeline.
module bsp_seg_queue import bsp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr,
  input  logic [2*NUM_CTRL*COORD_BITS-1:0] wdata,
  input  logic                             rd,
  output logic                             q_full,
  output logic                             q_empty,
  output logic [2*NUM_CTRL*COORD_BITS-1:0] rdata
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [2*NUM_CTRL*COORD_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign q_full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/bsp_back.sv @@
// Back end: per-sample weighted sum, divide by 384 and result register.
module bsp_back import bsp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  logic [2*NUM_CTRL*COORD_BITS-1:0] q_rdata,
  output logic                             q_rd,
  input  logic                             pop,
  output logic                             empty,
  output logic [COORD_BITS-1:0]            curve_x,
  output logic [COORD_BITS-1:0]            curve_y,
  output logic                             last_point
);

  localparam int SUM_W = COORD_BITS + WEIGHT_BITS;
  localparam int V_W   = COORD_BITS + 2;
  localparam int RECIP = (1 << V_W) / 3;

  logic                   advance;
  logic                   issue;
  logic [SAMPLE_BITS-1:0] k;

  logic [SUM_W-1:0] sum_x_next, sum_y_next;

  logic             a_valid, a_last;
  logic [SUM_W-1:0] a_sum_x, a_sum_y;

  logic [V_W-1:0]   a_v_x, a_v_y;
  logic [2*V_W-1:0] prod_x, prod_y;

  logic                  b_valid, b_last;
  logic [V_W-1:0]        b_v_x, b_v_y;
  logic [COORD_BITS-1:0] b_q_x, b_q_y;
  logic [V_W-1:0]        rem_x, rem_y;

  logic out_valid;

  assign advance = !out_valid || pop;
  assign issue   = advance && !q_empty;
  assign q_rd    = issue && (k == SAMPLE_BITS'(SAMPLES_PER_SEGMENT));
  assign empty   = !out_valid;

  always_comb begin
    sum_x_next = '0;
    sum_y_next = '0;
    for (int j = 0; j < NUM_CTRL; j++) begin
      sum_x_next = sum_x_next + SUM_W'(bsp_weight(k, 2'(j)))
                   * SUM_W'(q_rdata[j*COORD_BITS +: COORD_BITS]);
      sum_y_next = sum_y_next + SUM_W'(bsp_weight(k, 2'(j)))
                   * SUM_W'(q_rdata[(NUM_CTRL+j)*COORD_BITS +: COORD_BITS]);
    end
  end

  assign a_v_x  = a_sum_x[WEIGHT_SHIFT +: V_W];
  assign a_v_y  = a_sum_y[WEIGHT_SHIFT +: V_W];
  assign prod_x = (2*V_W)'(a_v_x) * (2*V_W)'(V_W'(RECIP));
  assign prod_y = (2*V_W)'(a_v_y) * (2*V_W)'(V_W'(RECIP));

  assign rem_x = b_v_x - V_W'(b_q_x) * V_W'(3);
  assign rem_y = b_v_y - V_W'(b_q_y) * V_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (issue) begin
        k <= q_rd ? '0 : k + 1'b1;
      end
      a_valid   <= issue;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_sum_x    <= sum_x_next;
      a_sum_y    <= sum_y_next;
      a_last     <= (k == SAMPLE_BITS'(SAMPLES_PER_SEGMENT));
      b_v_x      <= a_v_x;
      b_v_y      <= a_v_y;
      b_q_x      <= prod_x[V_W +: COORD_BITS];
      b_q_y      <= prod_y[V_W +: COORD_BITS];
      b_last     <= a_last;
      curve_x    <= (rem_x >= V_W'(3)) ? b_q_x + 1'b1 : b_q_x;
      curve_y    <= (rem_y >= V_W'(3)) ? b_q_y + 1'b1 : b_q_y;
      last_point <= b_last;
    end
  end

endmodule

@@ rtl/cubic_bspline_segment_points_core.sv @@
// Uniform cubic B-spline segment evaluator: top level.
// Each curve point passes the segment queue, then the a, b and output pipeline registers.
// Throughput: one curve point per cycle from the evaluation pipeline while a segment is queued
// and the output is not held by pop; a two-entry segment queue lets input run ahead of the results.
// Reset (rst, synchronous): clears the window, the held count, the queue and the pipeline.
module cubic_bspline_segment_points_core import bsp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] curve_x,
  output logic [COORD_BITS-1:0] curve_y,
  output logic                  last_point
);

  logic                             q_wr, q_rd, q_full, q_empty;
  logic [2*NUM_CTRL*COORD_BITS-1:0] q_wdata, q_rdata;

  bsp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .point_x (point_x),
    .point_y (point_y),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  bsp_seg_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .rd      (q_rd),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  bsp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .last_point (last_point)
  );

endmodule

@@ verif/cubic_bspline_segment_points_core_test.sv @@
// Testbench for the cubic B-spline segment evaluator: directed and random points.
`timescale 1ns / 1ps
module cubic_bspline_segment_points_core_test;
  import bsp_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int BASIS_SUM = 384;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_point_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  coord_t point_x = '0;
  coord_t point_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t curve_x;
  coord_t curve_y;
  logic   last_point;

  coord_t       hist_x [3];
  coord_t       hist_y [3];
  logic [1:0]   hist_count = '0;
  curve_point_t pending_curve_points [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycle_count = 0;
  bit           failed = 1'b0;

  cubic_bspline_segment_points_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .point_x    (point_x),
    .point_y    (point_y),
    .empty      (empty),
    .pop        (pop),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .last_point (last_point)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    curve_point_t want;
    if (!rst && pop && !empty) begin
      if (pending_curve_points.size() == 0) begin
        $error("unexpected curve point x=%0d y=%0d last=%0b", curve_x, curve_y, last_point);
        failed = 1'b1;
      end else begin
        want = pending_curve_points.pop_front();
        if (curve_x !== want.x) begin
          $error("curve_x expected %0d actual %0d", want.x, curve_x);
          failed = 1'b1;
        end
        if (curve_y !== want.y) begin
          $error("curve_y expected %0d actual %0d", want.y, curve_y);
          failed = 1'b1;
        end
        if (last_point !== want.last) begin
          $error("last_point expected %0b actual %0b", want.last, last_point);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic int unsigned basis_weight(int k, int j);
    int unsigned row [4];
    case (k)
      0:       row = '{64, 256, 64, 0};
      1:       row = '{27, 235, 121, 1};
      2:       row = '{8, 184, 184, 8};
      3:       row = '{1, 121, 235, 27};
      default: row = '{0, 64, 256, 64};
    endcase
    return row[j];
  endfunction

  function automatic coord_t blend_coord(int k, coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    int unsigned acc;
    acc = basis_weight(k, 0) * p0 + basis_weight(k, 1) * p1 +
          basis_weight(k, 2) * p2 + basis_weight(k, 3) * p3;
    return coord_t'(acc / BASIS_SUM);
  endfunction

  task automatic predict_segment_points(coord_t nx, coord_t ny);
    curve_point_t pt;
    if (hist_count < 2'd3) begin
      hist_x[hist_count] = nx;
      hist_y[hist_count] = ny;
      hist_count = hist_count + 2'd1;
    end else begin
      for (int k = 0; k <= SAMPLES_PER_SEGMENT; k++) begin
        pt.x = blend_coord(k, hist_x[0], hist_x[1], hist_x[2], nx);
        pt.y = blend_coord(k, hist_y[0], hist_y[1], hist_y[2], ny);
        pt.last = (k == SAMPLES_PER_SEGMENT);
        pending_curve_points.insert(pending_curve_points.size(), pt);
      end
      hist_x[0] = hist_x[1];
      hist_x[1] = hist_x[2];
      hist_x[2] = nx;
      hist_y[0] = hist_y[1];
      hist_y[1] = hist_y[2];
      hist_y[2] = ny;
    end
  endtask

  task automatic send_point(coord_t x, coord_t y);
    push <= 1'b1;
    point_x <= x;
    point_y <= y;
    do @(posedge clk); while (full);
    predict_segment_points(x, y);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    while (pending_curve_points.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom_range(2**COORD_BITS - 1));
    endcase
  endfunction

  task automatic test_warmup_and_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // hold: first three points fill the window and give no curve points
    send_point('1, '1);
    send_point('0, '0);
    send_point('1, '0);
    send_point('0, '1);
    repeat (4) send_point('1, '1);
    repeat (4) send_point('0, '0);
    send_point(coord_t'('h2AA), coord_t'('h155));
    send_point(coord_t'('h155), coord_t'('h2AA));
    send_point(coord_t'('h2AA), coord_t'('h155));
    send_point('1, '0);
    send_point('0, '1);
    send_point(coord_t'(1), coord_t'(2**COORD_BITS - 2));
    wait_results_done();
  endtask

  task automatic run_random_points(int unsigned count, int unsigned idle_pct,
                                   int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_point(pick_coord(), pick_coord());
    wait_results_done();
  endtask

  task automatic test_back_to_back();
    run_random_points(40, 0, 0);
  endtask

  task automatic test_sparse_sender();
    run_random_points(40, 74, 0);
  endtask

  task automatic test_stalled_receiver();
    run_random_points(40, 0, 74);
  endtask

  task automatic test_light_idle_both();
    run_random_points(40, 8, 8);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_warmup_and_extremes();
    test_back_to_back();
    test_sparse_sender();
    test_stalled_receiver();
    test_light_idle_both();
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule
